>>> rtl/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared widths, register indexes, status and pixel mode codes for the
// nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

   localparam int COORD_W     = 8;
   localparam int DIM_W       = 9;
   localparam int CH_W        = 8;
   localparam int MODE_W      = 2;
   localparam int ST_W        = 2;
   localparam int IDX_W       = 3;
   localparam int PIX_W       = 4 * CH_W;
   localparam int MAX_DIM_DEF = 256;

   // register indexes
   localparam logic [IDX_W-1:0] REG_SRC_W  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SRC_H  = 3'd1;
   localparam logic [IDX_W-1:0] REG_DST_W  = 3'd2;
   localparam logic [IDX_W-1:0] REG_DST_H  = 3'd3;
   localparam logic [IDX_W-1:0] REG_MODE   = 3'd4;

   // opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // pixel modes
   localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RGBA = 2'd2;

   // status codes
   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [ST_W-1:0] ST_FORMAT = 2'd3;

endpackage

>>> rtl/nnis_ifs.sv
// ----------------------------------------------------------------------------
// nnis channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface nnis_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [nnis_pkg::COORD_W-1:0] coord_x;
   logic [nnis_pkg::COORD_W-1:0] coord_y;
   logic [nnis_pkg::CH_W-1:0]    in_ch0;
   logic [nnis_pkg::CH_W-1:0]    in_ch1;
   logic [nnis_pkg::CH_W-1:0]    in_ch2;
   logic [nnis_pkg::CH_W-1:0]    in_ch3;

   modport source (output valid, opcode, coord_x, coord_y, in_ch0, in_ch1, in_ch2, in_ch3,
                   input ready);
   modport sink   (input valid, opcode, coord_x, coord_y, in_ch0, in_ch1, in_ch2, in_ch3,
                   output ready);
endinterface

interface nnis_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [nnis_pkg::CH_W-1:0] out_ch0;
   logic [nnis_pkg::CH_W-1:0] out_ch1;
   logic [nnis_pkg::CH_W-1:0] out_ch2;
   logic [nnis_pkg::CH_W-1:0] out_ch3;
   logic [nnis_pkg::ST_W-1:0] status;

   modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, status, input ready);
   modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, status, output ready);
endinterface

interface nnis_csr_if;
   logic                       valid;
   logic                       ready;
   logic [nnis_pkg::IDX_W-1:0] index;
   logic [nnis_pkg::DIM_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/nnis_ram.sv
// ----------------------------------------------------------------------------
// nnis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nnis_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nnis_div.sv
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in DW bits, so only DW steps are run.
// ----------------------------------------------------------------------------
module nnis_div #(
   parameter  int NW = 17,
   parameter  int DW = 9,
   localparam int CNT_W = $clog2(DW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);

   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    sh_ff, sh_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, sh_ff[DW-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = (trial >= {1'b0, div_ff});
      rem_in = rem_ff;
      sh_in  = sh_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      if (load) begin
         // upper part of the dividend is already below the divisor
         rem_in = DW'(dividend[NW-1:DW]);
         sh_in  = dividend[DW-1:0];
         div_in = divisor;
         cnt_in = CNT_W'(DW);
      end else if (busy) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         sh_in  = {sh_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = sh_ff;

endmodule

>>> rtl/nearest_neighbor_image_scaler_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top
// Nearest-neighbor scaler over a source frame store held in one RAM.
// ----------------------------------------------------------------------------
// A write beat stores one source pixel at (coord_x, coord_y); coordinates at
// or above MAX_DIM are dropped. A read beat maps the destination pixel to
// (x*src_width/dst_width, y*src_height/dst_height) and returns that source
// pixel after the two coordinate divisions, which run in parallel on
// bit-serial dividers that retire one quotient bit per cycle over the 9-bit
// dimension width, followed by address forming and the registered frame
// store read. A read that fails a check (empty dimension, out of range,
// unsupported format) returns zeros with the status, skipping the dividers
// and the store read. One item is in flight at a time; the result register
// lets the next item be accepted while a result waits. Store entries must be
// written before they are read. Dimension writes above MAX_DIM saturate.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_top #(
   parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   nnis_req_if.sink    req_ch,
   nnis_rsp_if.source  rsp_ch,
   nnis_csr_if.sink    csr_ch
);

   localparam int DIM_W   = nnis_pkg::DIM_W;
   localparam int COORD_W = nnis_pkg::COORD_W;
   localparam int CH_W    = nnis_pkg::CH_W;
   localparam int ST_W    = nnis_pkg::ST_W;
   localparam int MODE_W  = nnis_pkg::MODE_W;
   localparam int PIX_W   = nnis_pkg::PIX_W;
   localparam int NW      = COORD_W + DIM_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int AW      = $clog2(DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_ADR  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [DIM_W-1:0]  src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [DIM_W-1:0]  csr_sat;
   logic [ST_W-1:0]   st_ff, st_in, st_chk;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic [ST_W-1:0]   rsp_st_ff, rsp_st_in;

   logic              req_acc, rd_acc, wr_en, rd_en;
   logic [AW-1:0]     wr_addr;
   logic [PIX_W-1:0]  wr_data, rd_data;
   logic              div_load;
   logic [NW-1:0]     dvd_x, dvd_y;
   logic              busy_x, busy_y;
   logic [DIM_W-1:0]  q_x, q_y;
   logic              slot_free;

   // ---------------- configuration ----------------
   assign csr_ch.ready = 1'b1;
   assign csr_sat = (32'(csr_ch.data) > MAX_DIM) ? DIM_W'(MAX_DIM) : csr_ch.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= '0;
         src_h_ff <= '0;
         dst_w_ff <= '0;
         dst_h_ff <= '0;
         mode_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            nnis_pkg::REG_SRC_W: src_w_ff <= csr_sat;
            nnis_pkg::REG_SRC_H: src_h_ff <= csr_sat;
            nnis_pkg::REG_DST_W: dst_w_ff <= csr_sat;
            nnis_pkg::REG_DST_H: dst_h_ff <= csr_sat;
            nnis_pkg::REG_MODE:  mode_ff  <= csr_ch.data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- request side ----------------
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rd_acc       = req_acc && (req_ch.opcode == nnis_pkg::OP_READ);

   assign wr_en   = req_acc && (req_ch.opcode == nnis_pkg::OP_WRITE)
                    && (32'(req_ch.coord_x) < MAX_DIM) && (32'(req_ch.coord_y) < MAX_DIM);
   assign wr_addr = AW'(32'(req_ch.coord_y) * MAX_DIM + 32'(req_ch.coord_x));
   assign wr_data = {req_ch.in_ch3, req_ch.in_ch2, req_ch.in_ch1, req_ch.in_ch0};

   always_comb begin
      if (src_w_ff == '0 || src_h_ff == '0 || dst_w_ff == '0 || dst_h_ff == '0) begin
         st_chk = nnis_pkg::ST_EMPTY;
      end else if (DIM_W'(req_ch.coord_x) >= dst_w_ff
                   || DIM_W'(req_ch.coord_y) >= dst_h_ff) begin
         st_chk = nnis_pkg::ST_RANGE;
      end else if (mode_ff != nnis_pkg::MODE_RGB && mode_ff != nnis_pkg::MODE_RGBA) begin
         st_chk = nnis_pkg::ST_FORMAT;
      end else begin
         st_chk = nnis_pkg::ST_OK;
      end
   end

   assign div_load = rd_acc && (st_chk == nnis_pkg::ST_OK);
   assign dvd_x    = NW'(req_ch.coord_x) * NW'(src_w_ff);
   assign dvd_y    = NW'(req_ch.coord_y) * NW'(src_h_ff);

   nnis_div #(.NW(NW), .DW(DIM_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (dvd_x),
      .divisor  (dst_w_ff),
      .busy     (busy_x),
      .quotient (q_x)
   );

   nnis_div #(.NW(NW), .DW(DIM_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (dvd_y),
      .divisor  (dst_h_ff),
      .busy     (busy_y),
      .quotient (q_y)
   );

   // ---------------- frame store ----------------
   assign rd_en = (state_ff == S_RD);

   nnis_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // ---------------- sequencer ----------------
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      st_in        = st_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_st_in    = rsp_st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (rd_acc) begin
               st_in    = st_chk;
               state_in = (st_chk == nnis_pkg::ST_OK) ? S_DIV : S_OUT;
            end
         end
         S_DIV: begin
            if (!busy_x && !busy_y) begin
               state_in = S_ADR;
            end
         end
         S_ADR: begin
            addr_in  = AW'(32'(q_y) * MAX_DIM + 32'(q_x));
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = st_ff;
               if (st_ff != nnis_pkg::ST_OK) begin
                  rsp_pix_in = '0;
               end else if (mode_ff == nnis_pkg::MODE_RGB) begin
                  rsp_pix_in = {{CH_W{1'b0}}, rd_data[PIX_W-CH_W-1:0]};
               end else begin
                  rsp_pix_in = rd_data;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      st_ff      <= st_in;
      addr_ff    <= addr_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_st_ff  <= rsp_st_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.out_ch0 = rsp_pix_ff[CH_W-1:0];
   assign rsp_ch.out_ch1 = rsp_pix_ff[2*CH_W-1:CH_W];
   assign rsp_ch.out_ch2 = rsp_pix_ff[3*CH_W-1:2*CH_W];
   assign rsp_ch.out_ch3 = rsp_pix_ff[4*CH_W-1:3*CH_W];
   assign rsp_ch.status  = rsp_st_ff;

   // ---------------- assertions ----------------
   a_wr_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_IDLE))
      else $error("store written outside idle");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (busy_x == busy_y))
      else $error("dividers out of step");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result loaded outside output state");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff != nnis_pkg::ST_OK) |-> (rsp_pix_ff == '0))
      else $error("error result carries pixel data");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_OUT) |-> (!busy_x && !busy_y))
      else $error("divider busy outside divide phase");

endmodule
